// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl/core files
// no dependencies; the files that check their own logic include this header
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define XRG_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define XRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define XRG_ASSERT(label, prop, msg)
`define XRG_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// File: rtl/core/xrg_pkg.sv
// types, codes and constants of the xoroshiro range generator
// no dependencies; used by every module in rtl/core
package xrg_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W  = $clog2(DATA_W);

  localparam logic [DATA_W-1:0] TIME_MIX_MASK = 64'h0000_0000_AAAA_5555;
  localparam logic [DATA_W-1:0] SIGN_BIT      = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] SIGNED_MIN    = 64'h8000_0000_0000_0000;
  localparam logic [DATA_W-1:0] SIGNED_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [DATA_W-1:0] UNSIGNED_MAX  = 64'hFFFF_FFFF_FFFF_FFFF;

  localparam int unsigned ROT_A   = 24;
  localparam int unsigned SHIFT_B = 16;
  localparam int unsigned ROT_C   = 37;
  localparam int unsigned ROT_OUT = 7;

  typedef enum logic [1:0] {
    CMD_DRAW_UNSIGNED = 2'd0,
    CMD_DRAW_SIGNED   = 2'd1,
    CMD_SEED_WORDS    = 2'd2,
    CMD_SEED_TIME     = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MULT,
    ST_CHECK,
    ST_DIVIDE,
    ST_SUM,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } gen_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mod_status_t;

  function automatic logic [DATA_W-1:0] rotl64(input logic [DATA_W-1:0] x,
                                               input int unsigned k);
    return (x << k) | (x >> (DATA_W - k));
  endfunction

endpackage

// File: rtl/core/xrg_gen.sv
// xoroshiro128** state words, state update and scrambled output
// depends on xrg_pkg
module xrg_gen import xrg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  gen_ctrl_t         ctrl,
  input  logic [DATA_W-1:0] seed_zero,
  input  logic [DATA_W-1:0] seed_one,
  output logic [DATA_W-1:0] raw
);

  logic [DATA_W-1:0] word_zero;
  logic [DATA_W-1:0] word_one;
  logic [DATA_W-1:0] mixed_b;
  logic [DATA_W-1:0] prod5;
  logic [DATA_W-1:0] rot_prod;

  assign mixed_b  = word_one ^ word_zero;
  assign rot_prod = rotl64(prod5, ROT_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      word_zero <= '0;
      word_one  <= DATA_W'(1);
    end else if (ctrl.load) begin
      word_zero <= seed_zero;
      word_one  <= seed_one;
    end else if (ctrl.advance) begin
      word_zero <= rotl64(word_zero, ROT_A) ^ mixed_b ^ (mixed_b << SHIFT_B);
      word_one  <= rotl64(mixed_b, ROT_C);
    end
  end

  // output scrambler split into registered steps: s0*5 into prod5, then rotl(.,7)*9 into raw
  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      prod5 <= word_zero + {word_zero[DATA_W-3:0], 2'b00};
    end
    raw <= rot_prod + {rot_prod[DATA_W-4:0], 3'b000};
  end

endmodule

// File: rtl/core/xrg_mod.sv
// bit-serial restoring remainder unit, one dividend bit per cycle
// depends on xrg_pkg and assert_macros.svh
`include "assert_macros.svh"
module xrg_mod import xrg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DATA_W-1:0] dividend,
  input  logic [DATA_W-1:0] divisor,
  output mod_status_t       status,
  output logic [DATA_W-1:0] remainder
);

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] count;
  logic [DATA_W-1:0] dvd;
  logic [DATA_W-1:0] dsr;
  logic [DATA_W-1:0] rem;
  logic [DATA_W:0]   trial;
  logic [DATA_W:0]   diff;
  logic [DATA_W-1:0] rem_next;

  assign trial    = {rem, dvd[DATA_W-1]};
  assign diff     = trial - {1'b0, dsr};
  // borrow means the shifted remainder is still below the divisor
  assign rem_next = diff[DATA_W] ? trial[DATA_W-1:0] : diff[DATA_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(DATA_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      dvd <= dividend;
      dsr <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[DATA_W-2:0], 1'b0};
    end
  end

  assign status.busy = busy;
  assign status.done = done;
  assign remainder   = rem;

  `XRG_ASSERT(a_start_idle, start |-> !busy, "remainder unit started while busy")
  `XRG_ASSERT(a_fell_done, $fell(busy) |-> done, "busy dropped without done")
  `XRG_ASSERT(a_rem_range, done |-> (rem < dsr), "remainder not below divisor")

endmodule

// File: rtl/core/xoroshiro_range_generator.sv
// xoroshiro128** generator with bounded draws in [lo, hi), modulo bias kept;
// an empty range gives lo, a full range the raw value. Seeding commands load
// the state words and give no result. A draw passes MULT, CHECK and FINISH,
// and if its range is neither empty nor full also DIVIDE, where the bit-serial
// remainder unit spends one cycle per bit of the 64-bit generator value, and SUM.
// One item is handled at a time; a finished result sits in the output register
// while the next item is taken in. Depends on xrg_pkg, xrg_gen, xrg_mod and assert_macros.svh.
`include "assert_macros.svh"
module xoroshiro_range_generator import xrg_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  logic [1:0]        command,
  input  logic [DATA_W-1:0] first_operand,
  input  logic [DATA_W-1:0] second_operand,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [DATA_W-1:0] random_value
);

  state_t state, state_next;

  logic              accept;
  logic              is_draw;
  logic              out_free;
  logic              out_load;
  logic              mod_start;
  gen_ctrl_t         gen_ctrl;
  mod_status_t       mod_status;
  logic [DATA_W-1:0] time_mix;
  logic [DATA_W-1:0] seed_zero;
  logic [DATA_W-1:0] seed_one;
  logic [DATA_W-1:0] raw;
  logic [DATA_W-1:0] remainder;

  logic              signed_draw;
  logic [DATA_W-1:0] lo;
  logic [DATA_W-1:0] hi;
  logic              empty;
  logic              full;
  logic [DATA_W-1:0] span;
  logic [DATA_W-1:0] res;

  assign accept   = item_valid && !item_stall;
  assign is_draw  = (cmd_t'(command) == CMD_DRAW_UNSIGNED) ||
                    (cmd_t'(command) == CMD_DRAW_SIGNED);
  assign out_free = !result_valid || !result_stall;

  assign time_mix  = {first_operand[31:0], 32'h0} | (first_operand & TIME_MIX_MASK);
  assign seed_zero = (cmd_t'(command) == CMD_SEED_WORDS) ? first_operand : time_mix;
  assign seed_one  = (cmd_t'(command) == CMD_SEED_WORDS) ? second_operand : ~time_mix;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (accept && is_draw) state_next = ST_MULT;
      ST_MULT:   state_next = ST_CHECK;
      ST_CHECK:  state_next = (empty || full) ? ST_FINISH : ST_DIVIDE;
      ST_DIVIDE: if (mod_status.done) state_next = ST_SUM;
      ST_SUM:    state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    item_stall       = (state != ST_IDLE);
    gen_ctrl.load    = accept && !is_draw;
    gen_ctrl.advance = accept && is_draw;
    mod_start        = (state == ST_CHECK) && !empty && !full;
    out_load         = (state == ST_FINISH) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      signed_draw <= (cmd_t'(command) == CMD_DRAW_SIGNED);
      lo          <= first_operand;
      hi          <= second_operand;
    end
    if (state == ST_MULT) begin
      // signed compare by flipping the sign bits
      empty <= signed_draw ? ((hi ^ SIGN_BIT) <= (lo ^ SIGN_BIT)) : (hi <= lo);
      full  <= signed_draw ? (lo == SIGNED_MIN && hi == SIGNED_MAX)
                           : (lo == '0 && hi == UNSIGNED_MAX);
      span  <= hi - lo;
    end
    if (state == ST_CHECK) begin
      res <= empty ? lo : raw;
    end
    if (state == ST_SUM) begin
      res <= lo + remainder;
    end
    if (out_load) begin
      random_value <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  xrg_gen u_gen (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (gen_ctrl),
    .seed_zero (seed_zero),
    .seed_one  (seed_one),
    .raw       (raw)
  );

  xrg_mod u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (mod_start),
    .dividend  (raw),
    .divisor   (span),
    .status    (mod_status),
    .remainder (remainder)
  );

  `XRG_ASSERT_NEXT(a_draw_starts, (accept && is_draw), (state == ST_MULT), "draw not started")
  `XRG_ASSERT(a_result_src, $rose(result_valid) |-> ($past(state) == ST_FINISH), "stray result")
  `XRG_ASSERT(a_done_in_div, mod_status.done |-> (state == ST_DIVIDE), "remainder done off state")

endmodule

// File: verif/xoroshiro_range_generator_test.sv
// self-checking testbench for xoroshiro_range_generator: bounded draws and reseeding
// depends on xrg_pkg and the xoroshiro_range_generator rtl
`timescale 1ns / 1ps
module xoroshiro_range_generator_test;
  import xrg_pkg::*;

  localparam int unsigned CLK_HALF_NS   = 6;
  localparam int unsigned RESET_CYCLES  = 10;
  localparam int unsigned SETTLE_CYCLES = 120;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned PHASE_ITEMS   = 200;
  localparam int unsigned MAX_REPORTS   = 10;
  localparam longint unsigned TIMEOUT_NS = 64'd24_000_000;

  logic              clk;
  logic              rst            = 1'b1;
  logic              item_valid     = 1'b0;
  logic              item_stall;
  logic [1:0]        command        = CMD_DRAW_UNSIGNED;
  logic [DATA_W-1:0] first_operand  = '0;
  logic [DATA_W-1:0] second_operand = '0;
  logic              result_valid;
  logic              result_stall   = 1'b0;
  logic [DATA_W-1:0] random_value;

  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  bit          hold_request    = 1'b0;
  int unsigned holds_done      = 0;

  class draw_scoreboard;
    logic [DATA_W-1:0] word_zero;
    logic [DATA_W-1:0] word_one;
    logic [DATA_W-1:0] expected_draws[$];
    int unsigned items_seen;
    int unsigned draws_checked;
    int unsigned reseeds;
    int unsigned empty_draws;
    int unsigned full_draws;
    int unsigned mismatches;

    function new();
      word_zero     = '0;
      word_one      = 64'd1;
      items_seen    = 0;
      draws_checked = 0;
      reseeds       = 0;
      empty_draws   = 0;
      full_draws    = 0;
      mismatches    = 0;
    endfunction

    // one xoroshiro128** step, rotations written out as slices
    function logic [DATA_W-1:0] step_generator();
      logic [DATA_W-1:0] a;
      logic [DATA_W-1:0] b;
      logic [DATA_W-1:0] scaled;
      logic [DATA_W-1:0] raw;
      a = word_zero;
      b = word_one ^ word_zero;
      scaled = a * 64'd5;
      raw = {scaled[56:0], scaled[63:57]} * 64'd9;
      word_zero = {a[39:0], a[63:40]} ^ b ^ (b << SHIFT_B);
      word_one  = {b[26:0], b[63:27]};
      return raw;
    endfunction

    function void note_item(cmd_t cmd, logic [DATA_W-1:0] lo, logic [DATA_W-1:0] hi);
      logic [DATA_W-1:0] raw;
      logic [DATA_W-1:0] mixed;
      logic [DATA_W-1:0] value;
      bit                is_signed;
      bit                empty_span;
      bit                full_span;
      items_seen++;
      case (cmd)
        CMD_SEED_WORDS: begin
          word_zero = lo;
          word_one  = hi;
          reseeds++;
        end
        CMD_SEED_TIME: begin
          mixed = (lo << 32) | (lo & TIME_MIX_MASK);
          word_zero = mixed;
          word_one  = ~mixed;
          reseeds++;
        end
        default: begin
          raw = step_generator();
          is_signed  = (cmd == CMD_DRAW_SIGNED);
          empty_span = is_signed ? ($signed(hi) <= $signed(lo)) : (hi <= lo);
          full_span  = is_signed ? (lo == SIGNED_MIN && hi == SIGNED_MAX)
                                 : (lo == '0 && hi == UNSIGNED_MAX);
          if (empty_span) begin
            value = lo;
            empty_draws++;
          end else if (full_span) begin
            value = raw;
            full_draws++;
          end else begin
            // wrapping span and sum, modulo bias kept
            value = lo + raw % (hi - lo);
          end
          expected_draws.push_back(value);
        end
      endcase
    endfunction

    function void check_draw(logic [DATA_W-1:0] got);
      logic [DATA_W-1:0] want;
      if (expected_draws.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("error: random_value %h arrived with no draw pending", got);
        return;
      end
      want = expected_draws.pop_front();
      draws_checked++;
      if (got !== want) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("error: draw %0d random_value expected %h got %h",
                   draws_checked, want, got);
      end
    endfunction
  endclass

  draw_scoreboard board;

  xoroshiro_range_generator dut (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .command        (command),
    .first_operand  (first_operand),
    .second_operand (second_operand),
    .result_valid   (result_valid),
    .result_stall   (result_stall),
    .random_value   (random_value)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d draws still pending", board.expected_draws.size());
    $display("xoroshiro_range_generator_test failed");
    $finish;
  end

  // both sides of each handshake sampled at the edge, before any drive lands
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) board.check_draw(random_value);
      if (item_valid && !item_stall)
        board.note_item(cmd_t'(command), first_operand, second_operand);
    end
  end

  // output side: random stall, or a long counted hold when asked
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        holds_done++;
      end else begin
        result_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  function automatic logic [DATA_W-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // called at an edge; returns at the edge where the transfer happens
  task automatic send_item(cmd_t cmd, logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
    if ($urandom_range(99) < sender_idle_pct) begin
      item_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
    end
    item_valid     <= 1'b1;
    command        <= cmd;
    first_operand  <= a;
    second_operand <= b;
    @(posedge clk);
    while (item_stall) @(posedge clk);
  endtask

  // sender stops until every pending draw is back, then lets seeds settle
  task automatic wait_drained();
    item_valid <= 1'b0;
    while (board.expected_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_directed();
    send_item(CMD_DRAW_UNSIGNED, 64'd0, 64'd10);
    send_item(CMD_DRAW_UNSIGNED, 64'd0, UNSIGNED_MAX);
    send_item(CMD_DRAW_UNSIGNED, 64'd5, 64'd5);
    send_item(CMD_DRAW_UNSIGNED, UNSIGNED_MAX, 64'd0);
    send_item(CMD_DRAW_UNSIGNED, 64'd0, 64'd1);
    send_item(CMD_DRAW_UNSIGNED, UNSIGNED_MAX - 1, UNSIGNED_MAX);
    send_item(CMD_DRAW_UNSIGNED, 64'd1, UNSIGNED_MAX);
    send_item(CMD_DRAW_UNSIGNED, 64'd0, UNSIGNED_MAX - 1);
    send_item(CMD_DRAW_SIGNED, SIGNED_MIN, SIGNED_MAX);
    send_item(CMD_DRAW_SIGNED, 64'd5, -64'sd3);
    send_item(CMD_DRAW_SIGNED, SIGNED_MAX, SIGNED_MIN);
    send_item(CMD_DRAW_SIGNED, -64'sd100, 64'd100);
    send_item(CMD_DRAW_SIGNED, SIGNED_MIN, SIGNED_MAX - 1);
    send_item(CMD_DRAW_SIGNED, SIGNED_MIN + 1, SIGNED_MAX);
    send_item(CMD_DRAW_SIGNED, UNSIGNED_MAX, UNSIGNED_MAX);
    // all-zero state sticks at zero
    send_item(CMD_SEED_WORDS, 64'd0, 64'd0);
    send_item(CMD_DRAW_UNSIGNED, 64'd0, UNSIGNED_MAX);
    send_item(CMD_DRAW_SIGNED, -64'sd7, 64'd7);
    send_item(CMD_SEED_WORDS, UNSIGNED_MAX, UNSIGNED_MAX);
    send_item(CMD_DRAW_UNSIGNED, 64'd3, 64'd1000);
    send_item(CMD_SEED_TIME, 64'd0, UNSIGNED_MAX);
    send_item(CMD_DRAW_UNSIGNED, 64'd0, UNSIGNED_MAX);
    send_item(CMD_SEED_TIME, UNSIGNED_MAX, 64'd0);
    send_item(CMD_DRAW_SIGNED, SIGNED_MIN, SIGNED_MAX);
    send_item(CMD_SEED_TIME, rand64(), rand64());
  endtask

  task automatic send_random();
    int unsigned       pick;
    cmd_t              cmd;
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    pick = $urandom_range(99);
    if (pick < 8) begin
      if ($urandom_range(40) == 0) send_item(CMD_SEED_WORDS, '0, '0);
      else send_item(CMD_SEED_WORDS, rand64(), rand64());
    end else if (pick < 14) begin
      send_item(CMD_SEED_TIME, rand64(), rand64());
    end else begin
      cmd = ($urandom_range(1) != 0) ? CMD_DRAW_SIGNED : CMD_DRAW_UNSIGNED;
      lo = rand64();
      hi = rand64();
      case ($urandom_range(9))
        3, 4: hi = lo + $urandom_range(1, 1000);
        5: hi = lo + (64'd1 << $urandom_range(63));
        6: hi = lo - $urandom_range(3);
        7: begin
          lo = (cmd == CMD_DRAW_SIGNED) ? SIGNED_MIN : '0;
          hi = (cmd == CMD_DRAW_SIGNED) ? SIGNED_MAX : UNSIGNED_MAX;
        end
        8: begin
          lo = lo >> $urandom_range(63);
          hi = hi >> $urandom_range(63);
        end
        9: begin
          // at or just short of the full range
          lo = (cmd == CMD_DRAW_SIGNED) ? SIGNED_MIN + (lo & 64'h3) : (lo & 64'hFF);
          hi = (cmd == CMD_DRAW_SIGNED) ? SIGNED_MAX - (hi & 64'h3) : UNSIGNED_MAX - (hi & 64'h3);
        end
        default: ;
      endcase
      send_item(cmd, lo, hi);
    end
  endtask

  initial begin
    int unsigned phase;
    board = new();
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    run_directed();
    wait_drained();
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 0;
          // long output hold while items keep coming, fills the block
          hold_request = 1'b1;
        end
        1: begin
          sender_idle_pct = 56;
          recv_stall_pct  = 0;
        end
        2: begin
          sender_idle_pct = 0;
          recv_stall_pct  = 56;
        end
        default: begin
          sender_idle_pct = 28;
          recv_stall_pct  = 28;
        end
      endcase
      repeat (PHASE_ITEMS) send_random();
      wait_drained();
    end
    if (board.expected_draws.size() != 0) begin
      board.mismatches++;
      $display("error: %0d draws never arrived", board.expected_draws.size());
    end
    $display("covered %0d transfers in, %0d draws checked (%0d empty-range, %0d full-range)",
             board.items_seen, board.draws_checked, board.empty_draws, board.full_draws);
    $display("with %0d reseeds, %0d long output holds, four idle and stall patterns",
             board.reseeds, holds_done);
    if (board.mismatches == 0) begin
      $display("xoroshiro_range_generator_test passed");
    end else begin
      $display("%0d mismatches in total", board.mismatches);
      $display("xoroshiro_range_generator_test failed");
    end
    $finish;
  end

endmodule
